@@ rtl/subarray_target_sum_finder_top_defines.svh @@
// ----------------------------------------------------------------------------
// Subarray target sum finder assertion macros
// Shared property forms for the checks in the top level.
// ----------------------------------------------------------------------------
`ifndef SUBARRAY_TARGET_SUM_FINDER_TOP_DEFINES_SVH
`define SUBARRAY_TARGET_SUM_FINDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define STSF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define STSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/stsf_pkg.sv @@
// ----------------------------------------------------------------------------
// Subarray target sum finder package
// Widths, store geometry and the structures passed between the modules.
// ----------------------------------------------------------------------------
package stsf_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int ELEMENT_BITS = 32;
    localparam int ELEM_W       = 32;
    localparam int SUM_W        = 42;
    localparam int POS_W        = 11;
    localparam int STORE_DEPTH  = MAX_ELEMENTS + 1;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int OUT_TDATA_W  = ((2 * POS_W + 7) / 8) * 8;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] start_position;
        logic [POS_W-1:0] end_position;
    } result_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [SUM_W-1:0]  wr_data;
    } mem_req_t;

endpackage

@@ rtl/stsf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module stsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/stsf_search.sv @@
// ----------------------------------------------------------------------------
// Subarray target sum search engine
// Keeps the running sum and walks a monotone pointer over the prefix store.
// ----------------------------------------------------------------------------
module stsf_search (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [stsf_pkg::SUM_W-1:0] cfg_wr_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [stsf_pkg::ELEM_W-1:0] in_element,
    input  logic                    in_last,
    output stsf_pkg::mem_req_t      mem_req,
    input  logic [stsf_pkg::SUM_W-1:0] mem_rd_data,
    input  logic                    out_space,
    output logic                    res_push,
    output stsf_pkg::result_t       res_data
);

    import stsf_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } state_t;

    state_t           state_reg, state_next;
    logic [SUM_W-1:0] target_reg, target_next;
    logic [SUM_W:0]   diff_reg, diff_next;
    logic [SUM_W-1:0] run_reg, run_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] ptr_reg, ptr_next;
    logic [SUM_W-1:0] pval_reg, pval_next;
    logic             done_reg, done_next;
    logic             active_reg, active_next;
    logic             last_reg, last_next;
    logic             rdv_reg, rdv_next;

    logic [SUM_W-1:0] elem_ext;
    logic             active;
    logic             ge;
    logic [SUM_W-1:0] want;
    logic [POS_W-1:0] ptr_inc;
    logic             adv;
    logic             more;
    logic [SUM_W-1:0] cand;
    logic [POS_W-1:0] ptr_fin;
    logic             hit;
    logic             emit;

    assign elem_ext = {{(SUM_W - ELEMENT_BITS){1'b0}}, in_element[ELEMENT_BITS-1:0]};
    assign active   = !done_reg && (pos_reg < POS_W'(MAX_ELEMENTS));
    assign ge       = !diff_reg[SUM_W];
    assign want     = diff_reg[SUM_W-1:0];
    assign ptr_inc  = ptr_reg + POS_W'(1);
    assign adv      = active_reg && rdv_reg && ge && (mem_rd_data <= want);
    assign more     = adv && (ptr_inc < pos_reg);
    assign cand     = adv ? mem_rd_data : pval_reg;
    assign ptr_fin  = adv ? ptr_inc : ptr_reg;
    assign hit      = active_reg && ge && (cand == want);
    assign emit     = hit || (last_reg && !done_reg);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        target_next = target_reg;
        diff_next   = diff_reg;
        run_next    = run_reg;
        pos_next    = pos_reg;
        ptr_next    = ptr_reg;
        pval_next   = pval_reg;
        done_next   = done_reg;
        active_next = active_reg;
        last_next   = last_reg;
        rdv_next    = rdv_reg;
        mem_req     = '0;
        res_push    = 1'b0;
        res_data    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    active_next = active;
                    last_next   = in_last;
                    rdv_next    = active && (ptr_reg < pos_reg);
                    if (active)
                    begin
                        run_next  = run_reg + elem_ext;
                        diff_next = diff_reg + {1'b0, elem_ext};
                    end
                    mem_req.rd_en   = active && (ptr_reg < pos_reg);
                    mem_req.rd_addr = ADDR_W'(ptr_inc);
                    state_next      = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (more)
                begin
                    ptr_next        = ptr_inc;
                    pval_next       = mem_rd_data;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ADDR_W'(ptr_inc + POS_W'(1));
                end
                else if (!emit || out_space)
                begin
                    res_push = emit;
                    res_data.found = hit;
                    res_data.start_position = hit ? (ptr_fin + POS_W'(1)) : '0;
                    res_data.end_position   = hit ? (pos_reg + POS_W'(1)) : '0;
                    if (active_reg)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = ADDR_W'(pos_reg + POS_W'(1));
                        mem_req.wr_data = run_reg;
                        pos_next        = pos_reg + POS_W'(1);
                        ptr_next        = ptr_fin;
                        pval_next       = cand;
                        done_next       = done_reg || hit;
                    end
                    if (last_reg)
                    begin
                        run_next  = '0;
                        pos_next  = '0;
                        ptr_next  = '0;
                        pval_next = '0;
                        done_next = 1'b0;
                        diff_next = (SUM_W + 1)'(0) - {1'b0, target_reg};
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            target_next = cfg_wr_data;
            diff_next   = {1'b0, run_reg} - {1'b0, cfg_wr_data};
            ptr_next    = '0;
            pval_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            target_reg <= '0;
            diff_reg   <= '0;
            run_reg    <= '0;
            pos_reg    <= '0;
            ptr_reg    <= '0;
            pval_reg   <= '0;
            done_reg   <= 1'b0;
            active_reg <= 1'b0;
            last_reg   <= 1'b0;
            rdv_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            target_reg <= target_next;
            diff_reg   <= diff_next;
            run_reg    <= run_next;
            pos_reg    <= pos_next;
            ptr_reg    <= ptr_next;
            pval_reg   <= pval_next;
            done_reg   <= done_next;
            active_reg <= active_next;
            last_reg   <= last_next;
            rdv_reg    <= rdv_next;
        end
    end

endmodule

@@ rtl/stsf_out_stage.sv @@
// ----------------------------------------------------------------------------
// Subarray target sum result stage
// Holds one result request until the downstream side takes it.
// ----------------------------------------------------------------------------
module stsf_out_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  stsf_pkg::result_t       push_data,
    output logic                    space,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [stsf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                    m_axis_tuser
);

    import stsf_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign space = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
        if (push)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = data_reg.found;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2 * POS_W){1'b0}},
                            data_reg.end_position, data_reg.start_position};

endmodule

@@ rtl/subarray_target_sum_finder_top.sv @@
// An element is taken only in the idle state, so a new element waits until the last one is through;
// the store pointer steps at most 1024 times in all per sequence and target setting.
// A waiting result does not block the next element; a new result waits for the slot.
// Reset (rst_n, asynchronous) clears the target, the running sum and the sequence state;
// the prefix store needs no clearing pass, as only entries written this sequence are read.
// ----------------------------------------------------------------------------
// Subarray target sum finder top level
// Reports, per sequence, the first contiguous run of elements whose sum equals the target, or that there is none.
// ----------------------------------------------------------------------------
`include "subarray_target_sum_finder_top_defines.svh"

module subarray_target_sum_finder_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [stsf_pkg::SUM_W-1:0]       cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [stsf_pkg::ELEM_W-1:0]      s_axis_tdata,  // [31:0] element
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [stsf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [10:0] start, [21:11] end
    output logic                             m_axis_tuser   // [0] found
);

    import stsf_pkg::*;

    mem_req_t         mem_req;
    logic [SUM_W-1:0] mem_rd_data;
    logic             out_space;
    logic             res_push;
    result_t          res_data;

    stsf_ram #(
        .WIDTH (SUM_W),
        .DEPTH (STORE_DEPTH)
    ) u_prefix_store (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rd_data)
    );

    stsf_search u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_element  (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .out_space   (out_space),
        .res_push    (res_push),
        .res_data    (res_data)
    );

    stsf_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (res_push),
        .push_data     (res_data),
        .space         (out_space),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    `STSF_ASSERT_NOW(a_push_has_space, res_push, out_space, "result request overwrote a pending result")
    `STSF_ASSERT_NOW(a_none_is_zero, res_push && !res_data.found, (res_data.start_position == '0) && (res_data.end_position == '0), "no-hit result carries positions")
    `STSF_ASSERT_NOW(a_run_ordered, res_push && res_data.found, (res_data.start_position != '0) && (res_data.start_position <= res_data.end_position), "reported run has bad bounds")
    `STSF_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "element accepted while another is in work")

endmodule

@@ dv/subarray_target_sum_finder_top_tb.sv @@
// ----------------------------------------------------------------------------
// Subarray target sum finder testbench
// Streams element sequences into the block under several target settings,
// predicts the first matching run of every sequence from a prefix sum model,
// and compares each reported run with the prediction, with random sender
// gaps and receiver stalls throughout.
// ----------------------------------------------------------------------------
module subarray_target_sum_finder_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import stsf_pkg::*;

    localparam logic [SUM_W-1:0]  TARGET_MAX    = '1;
    localparam logic [ELEM_W-1:0] ELEMENT_MAX   = '1;
    localparam int                DRAIN_CYCLES  = 1100;
    localparam int                IDLE_LIMIT    = 200000;
    localparam int                PHASE_ITEMS   = 115;
    localparam int                MAX_REPORTS   = 40;

    class sum_run_scoreboard;
        logic [SUM_W-1:0] target;
        logic [SUM_W-1:0] running_sum;
        logic [SUM_W-1:0] prefix_sums [STORE_DEPTH];
        int unsigned      position_count;
        bit               run_found;
        result_t          expected_runs [$];
        int unsigned      mismatches;
        int unsigned      requests;
        int unsigned      elements_used;
        int unsigned      sequences;
        int unsigned      runs_checked;
        int unsigned      runs_found;
        int unsigned      runs_missing;

        function new();
            target = '0;
            foreach (prefix_sums[i])
                prefix_sums[i] = '0;
            clear_sequence();
        endfunction

        function void clear_sequence();
            running_sum    = '0;
            prefix_sums[0] = '0;
            position_count = 0;
            run_found      = 1'b0;
        endfunction

        function void set_target(logic [SUM_W-1:0] value);
            target = value;
        endfunction

        function int outstanding();
            return expected_runs.size();
        endfunction

        function void queue_run(result_t run);
            expected_runs = {expected_runs, run};
        endfunction

        function void note_element(logic [ELEM_W-1:0] element, logic last);
            logic [SUM_W-1:0] sum_now;
            logic [SUM_W-1:0] wanted;
            result_t          run;
            bit               hit;
            int               j;
            hit = 1'b0;
            requests++;
            if (!run_found && position_count < MAX_ELEMENTS) begin
                elements_used++;
                sum_now     = running_sum + SUM_W'(element[ELEMENT_BITS-1:0]);
                running_sum = sum_now;
                if (sum_now >= target) begin
                    wanted = sum_now - target;
                    for (j = int'(position_count); j >= 0; j--) begin
                        if (prefix_sums[j] == wanted) begin
                            run.found          = 1'b1;
                            run.start_position = POS_W'(j + 1);
                            run.end_position   = POS_W'(position_count + 1);
                            queue_run(run);
                            run_found = 1'b1;
                            hit       = 1'b1;
                            break;
                        end
                    end
                end
                position_count++;
                prefix_sums[position_count] = sum_now;
            end
            if (last) begin
                if (!run_found && !hit) begin
                    run.found          = 1'b0;
                    run.start_position = '0;
                    run.end_position   = '0;
                    queue_run(run);
                end
                sequences++;
                clear_sequence();
            end
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_REPORTS)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_run_result(result_t got);
            result_t want;
            runs_checked++;
            if (expected_runs.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%0b start=%0d end=%0d",
                                          got.found, got.start_position, got.end_position));
                return;
            end
            want = expected_runs.pop_front();
            if (want.found)
                runs_found++;
            else
                runs_missing++;
            if (got.found !== want.found)
                report_mismatch($sformatf("found %0b, expected %0b", got.found, want.found));
            if (got.start_position !== want.start_position)
                report_mismatch($sformatf("start %0d, expected %0d",
                                          got.start_position, want.start_position));
            if (got.end_position !== want.end_position)
                report_mismatch($sformatf("end %0d, expected %0d",
                                          got.end_position, want.end_position));
        endtask

        task report_leftovers();
            if (expected_runs.size() != 0)
                report_mismatch($sformatf("%0d expected results never arrived",
                                          expected_runs.size()));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n          = 1'b0;
    logic                   cfg_wr_en      = 1'b0;
    logic [SUM_W-1:0]       cfg_wr_data    = '0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    logic [ELEM_W-1:0]      s_axis_tdata   = '0;
    logic                   s_axis_tlast   = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    sum_run_scoreboard sb = new();

    logic [ELEM_W-1:0] seq_elems [$];
    int                burst_left    = 0;
    int                target_writes = 0;

    function automatic void append_element(input logic [ELEM_W-1:0] value);
        seq_elems = {seq_elems, value};
    endfunction

    subarray_target_sum_finder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : result_monitor
        result_t got;
        int      stall_mode;
        int      window;
        stall_mode = 0;
        window     = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready) begin
                got.found          = m_axis_tuser;
                got.start_position = m_axis_tdata[POS_W-1:0];
                got.end_position   = m_axis_tdata[2*POS_W-1:POS_W];
                sb.check_run_result(got);
            end
            if (window == 0) begin
                stall_mode = $urandom_range(0, 3);
                window     = $urandom_range(20, 200);
            end
            else begin
                window--;
            end
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= $urandom_range(0, 1);
                2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
                default: m_axis_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task automatic send_request(input logic [ELEM_W-1:0] element, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= element;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        sb.note_element(element, last);
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            s_axis_tvalid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(8, 20)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
            if ($urandom_range(0, 5) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic play_sequence();
        foreach (seq_elems[i])
            send_request(seq_elems[i], i == seq_elems.size() - 1);
        seq_elems.delete();
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0 && waited < IDLE_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_target(input logic [SUM_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_target(value);
        target_writes++;
    endtask

    task automatic build_sequence(input logic [SUM_W-1:0] tgt);
        logic [SUM_W-1:0]  half;
        logic [SUM_W-1:0]  remaining;
        logic [ELEM_W-1:0] span;
        logic [ELEM_W-1:0] part;
        int                style;
        int                parts;
        half  = (tgt >> 1) + 1;
        span  = (half > SUM_W'(ELEMENT_MAX)) ? ELEMENT_MAX : half[ELEM_W-1:0];
        style = $urandom_range(0, 99);
        if (style < 45) begin
            repeat ($urandom_range(1, 40))
                append_element(($urandom_range(0, 5) == 0) ? '0 : $urandom_range(span, 0));
        end
        else if (style < 80 && tgt < (SUM_W'(1) << 38)) begin
            repeat ($urandom_range(0, 10))
                append_element($urandom_range(span, 0));
            remaining = tgt;
            parts     = 0;
            do
            begin
                if (remaining > SUM_W'(ELEMENT_MAX))
                    part = $urandom_range(ELEMENT_MAX, 32'h8000_0000);
                else if (parts >= 5 || $urandom_range(0, 1) == 1)
                    part = remaining[ELEM_W-1:0];
                else
                    part = $urandom_range(remaining[ELEM_W-1:0], 0);
                append_element(part);
                remaining = remaining - SUM_W'(part);
                parts++;
            end
            while (remaining != 0);
            repeat ($urandom_range(0, 8))
                append_element($urandom_range(span, 0));
        end
        else begin
            repeat ($urandom_range(1, 24))
                append_element($urandom());
        end
    endtask

    initial
    begin : stimulus
        logic [SUM_W-1:0] phase_targets [6];
        int unsigned      phase_start;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        seq_elems = '{32'd0};
        play_sequence();
        seq_elems = '{32'd5, 32'd0, 32'd7};
        play_sequence();
        seq_elems = '{32'd3, 32'd4};
        play_sequence();
        seq_elems = '{ELEMENT_MAX};
        play_sequence();

        write_target(TARGET_MAX);
        seq_elems = '{ELEMENT_MAX, ELEMENT_MAX, ELEMENT_MAX};
        play_sequence();

        write_target(SUM_W'(5));
        seq_elems = '{32'd0, 32'd0, 32'd5};
        play_sequence();
        seq_elems = '{32'd2, 32'd3, 32'd9, 32'd1};
        play_sequence();
        seq_elems = '{32'd1, 32'd9, 32'd2, 32'd3};
        play_sequence();
        seq_elems = '{32'd6};
        play_sequence();

        phase_targets[0] = SUM_W'($urandom_range(300, 1));
        phase_targets[1] = '0;
        phase_targets[2] = SUM_W'({$urandom(), $urandom()}) % (SUM_W'(1) << 36)
                           + (SUM_W'(1) << 32);
        phase_targets[3] = SUM_W'($urandom_range(40, 1));
        phase_targets[4] = SUM_W'({$urandom(), $urandom()});
        phase_targets[5] = SUM_W'($urandom_range(5000, 1));
        foreach (phase_targets[p]) begin
            write_target(phase_targets[p]);
            phase_start = sb.requests;
            while (sb.requests - phase_start < PHASE_ITEMS) begin
                build_sequence(phase_targets[p]);
                play_sequence();
            end
        end

        wait_idle();
        sb.report_leftovers();
        $display("Sent %0d requests in %0d sequences over %0d target settings, %0d summed.",
                 sb.requests, sb.sequences, target_writes + 1, sb.elements_used);
        $display("Checked %0d results: %0d runs located, %0d without a run, %0d mismatches.",
                 sb.runs_checked, sb.runs_found, sb.runs_missing, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/stsf_pkg.sv
rtl/stsf_ram.sv
rtl/stsf_search.sv
rtl/stsf_out_stage.sv
rtl/subarray_target_sum_finder_top.sv
dv/subarray_target_sum_finder_top_tb.sv
